>>> hw/rtl/ordered_list_move_engine_top_defines.svh
// assertion macros for the ordered list move engine
`ifndef ORDERED_LIST_MOVE_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_MOVE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check clocked on clk, off while in reset
`define OLME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check clocked on clk, also during reset
`define OLME_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OLME_ASSERT(label, prop, msg)
`define OLME_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hw/rtl/olme_pkg.sv
package olme_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ITEM_W    = 7;
    localparam int TBL_DEPTH = MAX_ITEMS + 1;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    // input modes
    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_DUMP  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ENTRY   = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // operand selects of the datapath
    localparam int OPD_W = 3;
    localparam logic [OPD_W-1:0] OPD_ZERO = 3'd0;
    localparam logic [OPD_W-1:0] OPD_P    = 3'd1;
    localparam logic [OPD_W-1:0] OPD_S    = 3'd2;
    localparam logic [OPD_W-1:0] OPD_A    = 3'd3;
    localparam logic [OPD_W-1:0] OPD_B    = 3'd4;
    localparam logic [OPD_W-1:0] OPD_CUR  = 3'd5;

    // jump conditions
    localparam int JC_W = 3;
    localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
    localparam logic [JC_W-1:0] JC_GOTO     = 3'd1;
    localparam logic [JC_W-1:0] JC_DISPATCH = 3'd2;
    localparam logic [JC_W-1:0] JC_RIGHT    = 3'd3;
    localparam logic [JC_W-1:0] JC_LOOP     = 3'd4;

    localparam int PC_W = 4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ITEM_W-1:0] moved_item;
        logic [ITEM_W-1:0] anchor_item;
    } in_word_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item_number;
        logic [1:0]        status;
        logic              last;
    } out_word_t;

    // one microcode control word
    typedef struct packed {
        logic             in_ready;
        logic [OPD_W-1:0] rd_sel;
        logic             latch_ps;
        logic             latch_cur;
        logic             succ_we;
        logic [OPD_W-1:0] succ_addr;
        logic [OPD_W-1:0] succ_data;
        logic             pred_we;
        logic [OPD_W-1:0] pred_addr;
        logic [OPD_W-1:0] pred_data;
        logic             emit;
        logic [1:0]       emit_status;
        logic             k_inc;
        logic [JC_W-1:0]  jc;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic is_dump;
        logic is_bad;
        logic is_right;
        logic dump_done;
        logic room;
    } seq_flags_t;

endpackage

>>> hw/rtl/ordered_list_move_engine_top.sv
// ordered list move engine
// keeps an order of items 1..count as successor and predecessor link tables,
// with a sentinel entry at index 0 standing before the first and after the last
// input channel in_valid/in_ready carries one word: mode, moved_item, anchor_item
// output channel out_valid/out_ready carries result words: item_number, status, last
// cfg_we/cfg_wdata write the item count (saturated to 1..64), restoring order 1..count
// a microcoded sequencer steps through a small rom program; one table port per cycle
// move: reads and unlinks the moved item, reads the anchor, splices, then loads the result word
// ignored command (same item, out of range, unknown mode): tables untouched, ignored result word loaded
// dump: reads the sentinel's successor, then walks the successor chain and loads one result
// word per item, the last one flagged last; one successor link read per word
// a new word is taken only once the previous one is fully handled
// reset: count 64, order 1..64, output empty; link table valid bits clear at once,
// so an unwritten entry reads as its restored-order value with no clearing pass
// a stalled receiver holds the result register; the program waits in its emit step
`include "ordered_list_move_engine_top_defines.svh"

module ordered_list_move_engine_top
    import olme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_word,
    input  logic              cfg_we,
    input  logic [ITEM_W-1:0] cfg_wdata
);

    // restored-order successor link of entry idx
    function automatic logic [ITEM_W-1:0] succ_init(input logic [ADDR_W-1:0] idx,
                                                    input logic [ITEM_W-1:0] n);
        logic [ITEM_W-1:0] v;
        v = ITEM_W'(idx);
        return (v < n) ? v + 1'b1 : '0;
    endfunction

    // restored-order predecessor link of entry idx
    function automatic logic [ITEM_W-1:0] pred_init(input logic [ADDR_W-1:0] idx,
                                                    input logic [ITEM_W-1:0] n);
        logic [ITEM_W-1:0] v;
        v = ITEM_W'(idx);
        if (v == '0)
        begin
            return n;
        end
        return (v <= n) ? v - 1'b1 : '0;
    endfunction

    // links beyond the table point at the sentinel
    function automatic logic [ADDR_W-1:0] slot(input logic [ITEM_W-1:0] v);
        return (v <= ITEM_W'(MAX_ITEMS)) ? ADDR_W'(v) : '0;
    endfunction

    ctrl_t             ctrl;
    logic              go;
    seq_flags_t        flags;

    // control state
    logic [ITEM_W-1:0] count_reg;
    logic              out_valid_reg;

    // datapath registers
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] a_reg;
    logic [ADDR_W-1:0] b_reg;
    logic [ADDR_W-1:0] p_reg;
    logic [ADDR_W-1:0] s_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [ITEM_W-1:0] k_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    out_word_t         out_word_reg;
    out_word_t         out_word_next;

    logic              in_fire;
    logic              emit_fire;
    logic              in_bad;
    logic [ITEM_W-1:0] cfg_sat;
    logic [ADDR_W-1:0] rd_addr;
    logic [ITEM_W-1:0] succ_rdata;
    logic [ITEM_W-1:0] pred_rdata;
    logic              succ_rvalid;
    logic              pred_rvalid;
    logic [ITEM_W-1:0] succ_eff;
    logic [ITEM_W-1:0] pred_eff;
    logic [ADDR_W-1:0] succ_waddr;
    logic [ADDR_W-1:0] pred_waddr;
    logic [ADDR_W-1:0] succ_wdata;
    logic [ADDR_W-1:0] pred_wdata;

    function automatic logic [ADDR_W-1:0] operand(input logic [OPD_W-1:0] sel,
                                                  input logic [ADDR_W-1:0] p,
                                                  input logic [ADDR_W-1:0] s,
                                                  input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b,
                                                  input logic [ADDR_W-1:0] cur);
        logic [ADDR_W-1:0] r;
        case (sel)
            OPD_P:   r = p;
            OPD_S:   r = s;
            OPD_A:   r = a;
            OPD_B:   r = b;
            OPD_CUR: r = cur;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign in_ready  = ctrl.in_ready;
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = ctrl.emit && go;

    // move command checks, taken straight from the input word
    assign in_bad = (in_word.mode != MODE_LEFT && in_word.mode != MODE_RIGHT)
                 || (in_word.moved_item == in_word.anchor_item)
                 || (in_word.moved_item == '0) || (in_word.moved_item > count_reg)
                 || (in_word.anchor_item == '0) || (in_word.anchor_item > count_reg);

    assign flags.in_valid  = in_valid;
    assign flags.is_dump   = (in_word.mode == MODE_DUMP);
    assign flags.is_bad    = in_bad;
    assign flags.is_right  = (mode_reg == MODE_RIGHT);
    assign flags.dump_done = (k_reg == count_reg);
    assign flags.room      = !out_valid_reg || out_ready;

    olme_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .go    (go)
    );

    // table access
    assign rd_addr    = operand(ctrl.rd_sel, p_reg, s_reg, a_reg, b_reg, cur_reg);
    assign succ_waddr = operand(ctrl.succ_addr, p_reg, s_reg, a_reg, b_reg, cur_reg);
    assign succ_wdata = operand(ctrl.succ_data, p_reg, s_reg, a_reg, b_reg, cur_reg);
    assign pred_waddr = operand(ctrl.pred_addr, p_reg, s_reg, a_reg, b_reg, cur_reg);
    assign pred_wdata = operand(ctrl.pred_data, p_reg, s_reg, a_reg, b_reg, cur_reg);

    olme_link_table u_succ (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_we),
        .we     (ctrl.succ_we),
        .waddr  (succ_waddr),
        .wdata  (ITEM_W'(succ_wdata)),
        .raddr  (rd_addr),
        .rdata  (succ_rdata),
        .rvalid (succ_rvalid)
    );

    olme_link_table u_pred (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_we),
        .we     (ctrl.pred_we),
        .waddr  (pred_waddr),
        .wdata  (ITEM_W'(pred_wdata)),
        .raddr  (rd_addr),
        .rdata  (pred_rdata),
        .rvalid (pred_rvalid)
    );

    // unwritten entries read as the restored order
    assign succ_eff = succ_rvalid ? succ_rdata : succ_init(rd_addr_reg, count_reg);
    assign pred_eff = pred_rvalid ? pred_rdata : pred_init(rd_addr_reg, count_reg);

    // saturate the written count into 1..MAX_ITEMS
    assign cfg_sat = (cfg_wdata == '0) ? ITEM_W'(1)
                   : (cfg_wdata > ITEM_W'(MAX_ITEMS)) ? ITEM_W'(MAX_ITEMS) : cfg_wdata;

    always_comb
    begin
        out_word_next.status = ctrl.emit_status;
        if (ctrl.emit_status == ST_ENTRY)
        begin
            out_word_next.item_number = ITEM_W'(cur_reg);
            out_word_next.last        = (k_reg + 1'b1 == count_reg);
        end
        else
        begin
            out_word_next.item_number = '0;
            out_word_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= ITEM_W'(MAX_ITEMS);
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_sat;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire)
            begin
                k_reg <= '0;
            end
            else if (ctrl.k_inc && go)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        if (in_fire)
        begin
            mode_reg <= in_word.mode;
            a_reg    <= slot(in_word.moved_item);
            b_reg    <= slot(in_word.anchor_item);
        end
        if (ctrl.latch_ps)
        begin
            p_reg <= slot(pred_eff);
            s_reg <= slot(succ_eff);
        end
        if (ctrl.latch_cur)
        begin
            cur_reg <= slot(succ_eff);
        end
        if (emit_fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // count stays in its legal range once reset has been seen
    `OLME_ASSERT_ALWAYS(a_count_range, !rst_n || ((count_reg != '0) && (count_reg <= ITEM_W'(MAX_ITEMS))), "item count out of range")
    // an accepted word takes the sequencer out of its idle step
    `OLME_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "input taken again while busy")
    // a dump entry always names an item in use
    `OLME_ASSERT(a_dump_item, (out_valid && out_word.status == ST_ENTRY) |-> ((out_word.item_number != '0) && (out_word.item_number <= count_reg)), "dump produced an item out of range")
    // a result is never loaded over one still waiting
    `OLME_ASSERT(a_no_overwrite, (out_valid && !out_ready) |=> $stable(out_word), "pending result overwritten")

endmodule

>>> hw/rtl/olme_ram.sv
module olme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/olme_link_table.sv
module olme_link_table
    import olme_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ITEM_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ITEM_W-1:0] rdata,
    output logic              rvalid
);

    // entry written since the last order restore
    logic [TBL_DEPTH-1:0] vld_reg;
    logic                 rvalid_reg;

    olme_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= vld_reg[raddr];
        end
    end

    assign rvalid = rvalid_reg;

endmodule

>>> hw/rtl/olme_useq.sv
module olme_useq
    import olme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_t      ctrl,
    output logic       go
);

    // program steps
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_M_RDA    = 4'd1;
    localparam logic [PC_W-1:0] STEP_M_LATA   = 4'd2;
    localparam logic [PC_W-1:0] STEP_M_UNLINK = 4'd3;
    localparam logic [PC_W-1:0] STEP_M_RDB    = 4'd4;
    localparam logic [PC_W-1:0] STEP_M_LATB   = 4'd5;
    localparam logic [PC_W-1:0] STEP_M_L1     = 4'd6;
    localparam logic [PC_W-1:0] STEP_M_L2     = 4'd7;
    localparam logic [PC_W-1:0] STEP_M_R1     = 4'd8;
    localparam logic [PC_W-1:0] STEP_M_R2     = 4'd9;
    localparam logic [PC_W-1:0] STEP_E_DONE   = 4'd10;
    localparam logic [PC_W-1:0] STEP_E_IGN    = 4'd11;
    localparam logic [PC_W-1:0] STEP_D_RD0    = 4'd12;
    localparam logic [PC_W-1:0] STEP_D_LAT    = 4'd13;
    localparam logic [PC_W-1:0] STEP_D_EMIT   = 4'd14;
    localparam logic [PC_W-1:0] STEP_D_NEXT   = 4'd15;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_t           c;

    // microcode rom
    always_comb
    begin
        c = '0;
        case (pc_reg)
            STEP_IDLE:
            begin
                c.in_ready = 1'b1;
                c.jc       = JC_DISPATCH;
            end
            STEP_M_RDA:
            begin
                c.rd_sel = OPD_A;
            end
            STEP_M_LATA:
            begin
                c.latch_ps = 1'b1;
            end
            STEP_M_UNLINK:
            begin
                c.succ_we   = 1'b1;
                c.succ_addr = OPD_P;
                c.succ_data = OPD_S;
                c.pred_we   = 1'b1;
                c.pred_addr = OPD_S;
                c.pred_data = OPD_P;
            end
            STEP_M_RDB:
            begin
                c.rd_sel = OPD_B;
            end
            STEP_M_LATB:
            begin
                c.latch_ps = 1'b1;
                c.jc       = JC_RIGHT;
                c.target   = STEP_M_R1;
            end
            STEP_M_L1:
            begin
                c.succ_we   = 1'b1;
                c.succ_addr = OPD_P;
                c.succ_data = OPD_A;
                c.pred_we   = 1'b1;
                c.pred_addr = OPD_A;
                c.pred_data = OPD_P;
            end
            STEP_M_L2:
            begin
                c.succ_we   = 1'b1;
                c.succ_addr = OPD_A;
                c.succ_data = OPD_B;
                c.pred_we   = 1'b1;
                c.pred_addr = OPD_B;
                c.pred_data = OPD_A;
                c.jc        = JC_GOTO;
                c.target    = STEP_E_DONE;
            end
            STEP_M_R1:
            begin
                c.succ_we   = 1'b1;
                c.succ_addr = OPD_B;
                c.succ_data = OPD_A;
                c.pred_we   = 1'b1;
                c.pred_addr = OPD_A;
                c.pred_data = OPD_B;
            end
            STEP_M_R2:
            begin
                c.succ_we   = 1'b1;
                c.succ_addr = OPD_A;
                c.succ_data = OPD_S;
                c.pred_we   = 1'b1;
                c.pred_addr = OPD_S;
                c.pred_data = OPD_A;
            end
            STEP_E_DONE:
            begin
                c.emit        = 1'b1;
                c.emit_status = ST_DONE;
                c.jc          = JC_GOTO;
                c.target      = STEP_IDLE;
            end
            STEP_E_IGN:
            begin
                c.emit        = 1'b1;
                c.emit_status = ST_IGNORED;
                c.jc          = JC_GOTO;
                c.target      = STEP_IDLE;
            end
            STEP_D_RD0:
            begin
                c.rd_sel = OPD_ZERO;
            end
            STEP_D_LAT:
            begin
                c.latch_cur = 1'b1;
            end
            STEP_D_EMIT:
            begin
                c.rd_sel      = OPD_CUR;
                c.emit        = 1'b1;
                c.emit_status = ST_ENTRY;
                c.k_inc       = 1'b1;
            end
            STEP_D_NEXT:
            begin
                c.latch_cur = 1'b1;
                c.jc        = JC_LOOP;
                c.target    = STEP_IDLE;
            end
            default:
            begin
                c.jc     = JC_GOTO;
                c.target = STEP_IDLE;
            end
        endcase
    end

    // emit steps hold while the output register is full
    assign go = !(c.emit && !flags.room);

    always_comb
    begin
        pc_next = pc_reg + 1'b1;
        case (c.jc)
            JC_NEXT:
            begin
                pc_next = pc_reg + 1'b1;
            end
            JC_GOTO:
            begin
                pc_next = c.target;
            end
            JC_DISPATCH:
            begin
                if (!flags.in_valid)
                begin
                    pc_next = pc_reg;
                end
                else if (flags.is_dump)
                begin
                    pc_next = STEP_D_RD0;
                end
                else if (flags.is_bad)
                begin
                    pc_next = STEP_E_IGN;
                end
                else
                begin
                    pc_next = STEP_M_RDA;
                end
            end
            JC_RIGHT:
            begin
                pc_next = flags.is_right ? c.target : pc_reg + 1'b1;
            end
            JC_LOOP:
            begin
                pc_next = flags.dump_done ? c.target : pc_reg - 1'b1;
            end
            default:
            begin
                pc_next = STEP_IDLE;
            end
        endcase
        if (!go)
        begin
            pc_next = pc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = c;

endmodule

>>> dv/ordered_list_move_engine_top_test.sv
module ordered_list_move_engine_top_test;
    import olme_pkg::*;

    // mode code with no meaning, the block must answer it as ignored
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // cycles with no word moving on either channel before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // settle time after the last result word, until the block is idle again
    localparam int SETTLE_CYCLES = 12;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_word_t          in_word   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_word_t         out_word;
    logic              cfg_we    = 1'b0;
    logic [ITEM_W-1:0] cfg_wdata = '0;

    // idle rates in percent of cycles, changed between traffic phases
    int send_idle_pct = 27;
    int recv_idle_pct = 80;
    int errors        = 0;
    int stall_cycles  = 0;

    // predicted link tables, index 0 is the sentinel before the first and after the last
    logic [ITEM_W-1:0] succ_link [0:MAX_ITEMS];
    logic [ITEM_W-1:0] pred_link [0:MAX_ITEMS];
    int unsigned       item_count;

    // result words still owed by the block, oldest first
    out_word_t pending_results [$];

    ordered_list_move_engine_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // a link value past the table reads as the sentinel
    function automatic int unsigned link_slot(input int unsigned v);
        return (v <= MAX_ITEMS) ? v : 0;
    endfunction

    // order 1..count, entries above count cleared
    function automatic void restore_chain();
        for (int i = 0; i <= MAX_ITEMS; i++)
        begin
            succ_link[i] = '0;
            pred_link[i] = '0;
        end
        for (int i = 0; i < int'(item_count); i++)
            succ_link[i] = ITEM_W'(i + 1);
        for (int i = 1; i <= int'(item_count); i++)
            pred_link[i] = ITEM_W'(i - 1);
        pred_link[0] = ITEM_W'(item_count);
    endfunction

    // update the predicted tables for one accepted word and queue its result words
    function automatic void predict_command(input in_word_t w);
        int unsigned a;
        int unsigned b;
        int unsigned p;
        int unsigned s;
        int unsigned cur;
        out_word_t   r;
        a = w.moved_item;
        b = w.anchor_item;
        // dump walks the successor chain from the sentinel, one word per item
        if (w.mode == MODE_DUMP)
        begin
            cur = link_slot(succ_link[0]);
            for (int unsigned k = 0; k < item_count; k++)
            begin
                r.item_number = ITEM_W'(cur);
                r.status      = ST_ENTRY;
                r.last        = (k + 1 == item_count);
                pending_results.push_back(r);
                cur = link_slot(succ_link[cur]);
            end
            return;
        end
        r.item_number = '0;
        r.last        = 1'b1;
        // unknown mode, same item or either number outside 1..count: tables untouched
        if ((w.mode != MODE_LEFT && w.mode != MODE_RIGHT) || a == b
            || a < 1 || a > item_count || b < 1 || b > item_count)
        begin
            r.status = ST_IGNORED;
            pending_results.push_back(r);
            return;
        end
        // take the moved item out of the ring
        p = link_slot(pred_link[a]);
        s = link_slot(succ_link[a]);
        succ_link[p] = ITEM_W'(s);
        pred_link[s] = ITEM_W'(p);
        if (w.mode == MODE_LEFT)
        begin
            // splice between the anchor's predecessor and the anchor
            p = link_slot(pred_link[b]);
            succ_link[p] = ITEM_W'(a);
            pred_link[a] = ITEM_W'(p);
            succ_link[a] = ITEM_W'(b);
            pred_link[b] = ITEM_W'(a);
        end
        else
        begin
            // splice between the anchor and its successor
            s = link_slot(succ_link[b]);
            succ_link[b] = ITEM_W'(a);
            pred_link[a] = ITEM_W'(b);
            succ_link[a] = ITEM_W'(s);
            pred_link[s] = ITEM_W'(a);
        end
        r.status = ST_DONE;
        pending_results.push_back(r);
    endfunction

    // present one word, with random gaps before it, and hold it until taken
    // entered and left at a rising edge; valid stays high for a word that follows at once
    task automatic send_cmd(input logic [1:0] mode, input int unsigned a, input int unsigned b);
        in_word_t w;
        w.mode        = mode;
        w.moved_item  = ITEM_W'(a);
        w.anchor_item = ITEM_W'(b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_command(w);
    endtask

    // stop sending and wait until every owed result word has come, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the item count while the block is idle; out of range values saturate
    task automatic set_item_count(input int unsigned v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= ITEM_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        item_count = (v == 0) ? 1 : (v > MAX_ITEMS) ? MAX_ITEMS : v;
        restore_chain();
    endtask

    // order after reset, dump fields all ones
    task automatic test_reset_order();
        send_cmd(MODE_DUMP, 127, 127);
    endtask

    // moves at both ends of the order, adjacent items, then a full dump
    task automatic test_move_extremes();
        send_cmd(MODE_LEFT, 64, 1);
        send_cmd(MODE_RIGHT, 1, 64);
        send_cmd(MODE_LEFT, 2, 3);
        send_cmd(MODE_RIGHT, 32, 31);
        send_cmd(MODE_DUMP, 0, 0);
    endtask

    // every reason for an ignored move, then a dump shows nothing changed
    task automatic test_ignored_commands();
        send_cmd(MODE_LEFT, 7, 7);
        send_cmd(MODE_RIGHT, 0, 5);
        send_cmd(MODE_LEFT, 5, 0);
        send_cmd(MODE_RIGHT, 65, 1);
        send_cmd(MODE_LEFT, 1, 127);
        send_cmd(MODE_UNUSED, 3, 4);
        send_cmd(MODE_UNUSED, 127, 0);
        send_cmd(MODE_DUMP, 85, 42);
    endtask

    // count writes past both limits and inside the range, each one restoring the order
    task automatic test_count_writes();
        set_item_count(0);
        send_cmd(MODE_DUMP, 1, 1);
        send_cmd(MODE_RIGHT, 1, 1);
        send_cmd(MODE_LEFT, 1, 2);
        set_item_count(127);
        send_cmd(MODE_LEFT, 64, 63);
        set_item_count(2);
        send_cmd(MODE_LEFT, 2, 1);
        send_cmd(MODE_DUMP, 127, 0);
        set_item_count(65);
        send_cmd(MODE_DUMP, 0, 127);
    endtask

    // runs of random moves and dumps under a fresh count, with some malformed words mixed in
    // each new count first waits for all owed words, so the sender pauses often
    task automatic test_random_traffic(input int target);
        int unsigned useful;
        int unsigned run_left;
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        useful   = 0;
        run_left = 0;
        while (useful < target)
        begin
            if (run_left == 0)
            begin
                // mostly small lists so dumps stay short
                pick = $urandom_range(99);
                if (pick < 6)
                    set_item_count(1);
                else if (pick < 18)
                    set_item_count(MAX_ITEMS);
                else if (pick < 26)
                    set_item_count($urandom_range(1) ? 0 : $urandom_range(MAX_ITEMS + 1, 127));
                else
                    set_item_count($urandom_range(2, 12));
                run_left = $urandom_range(8, 20);
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                send_cmd(MODE_DUMP, $urandom_range(127), $urandom_range(127));
                useful++;
            end
            else if (pick < 30 || item_count < 2)
            begin
                // malformed words
                case ($urandom_range(3))
                    0:
                        send_cmd(2'($urandom_range(3)), $urandom_range(127), $urandom_range(127));
                    1:
                    begin
                        a = $urandom_range(1, item_count);
                        send_cmd(2'($urandom_range(1)), a, a);
                    end
                    2:
                        send_cmd(MODE_UNUSED, $urandom_range(1, item_count),
                                 $urandom_range(1, item_count));
                    default:
                    begin
                        a = $urandom_range(item_count + 1, 127);
                        b = $urandom_range(1, item_count);
                        if ($urandom_range(1))
                        begin
                            t = a;
                            a = b;
                            b = t;
                        end
                        send_cmd(2'($urandom_range(1)), a, b);
                    end
                endcase
            end
            else
            begin
                // well-formed move, two distinct items in range
                a = $urandom_range(1, item_count);
                b = $urandom_range(1, item_count - 1);
                if (b >= a)
                    b++;
                send_cmd($urandom_range(1) ? MODE_RIGHT : MODE_LEFT, a, b);
                useful++;
            end
        end
    endtask

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // compare each taken result word with the oldest owed one
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none owed: item %0d status %0d last %0d",
                         $time, out_word.item_number, out_word.status, out_word.last);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_word.item_number !== want.item_number)
                begin
                    $display("%0t: item_number expected %0d got %0d",
                             $time, want.item_number, out_word.item_number);
                    errors++;
                end
                if (out_word.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_word.status);
                    errors++;
                end
                if (out_word.last !== want.last)
                begin
                    $display("%0t: last expected %0d got %0d",
                             $time, want.last, out_word.last);
                    errors++;
                end
            end
        end
    end

    // hang detection: no word moving on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        item_count = MAX_ITEMS;
        restore_chain();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow sender, slower receiver
        test_reset_order();
        test_move_extremes();
        test_ignored_commands();
        test_count_writes();
        test_random_traffic(35);

        // fast-ish receiver, slow sender
        send_idle_pct = 80;
        recv_idle_pct = 27;
        test_random_traffic(35);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(35);

        drain_results();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/olme_pkg.sv
hw/rtl/olme_ram.sv
hw/rtl/olme_link_table.sv
hw/rtl/olme_useq.sv
hw/rtl/ordered_list_move_engine_top.sv
dv/ordered_list_move_engine_top_test.sv
